>>> hw/rtl/hlpa_pkg.sv
package hlpa_pkg;

   localparam int HopCountDefault = 20;
   localparam logic [31:0] FnvPrime = 32'd16777619;
   localparam logic [7:0] LinkVersion = 8'd1;
   localparam logic [7:0] LinkMsgControl = 8'd1;
   localparam logic [31:0] SeqNever = 32'hFFFF_FFFF;

   localparam logic [2:0] CsrKeySeed = 3'd0;
   localparam logic [2:0] CsrFailsafe = 3'd1;
   localparam logic [2:0] CsrGrace = 3'd2;
   localparam logic [2:0] CsrLookahead = 3'd3;
   localparam logic [2:0] CsrTick = 3'd4;
   localparam logic [2:0] CsrHatId = 3'd5;
   localparam logic [2:0] CsrRacerId = 3'd6;

   typedef struct packed {
      logic        pkt;
      logic        hdr_ok;
      logic [31:0] seq;
      logic [7:0]  left;
      logic [7:0]  right;
      logic        check_ok;
   } job_type;

   function automatic logic [6:0] chan_lookup(input logic [4:0] idx);
      logic [6:0] r;
      unique case (idx)
         5'd0: r = 7'd2;   5'd1: r = 7'd26;  5'd2: r = 7'd62;  5'd3: r = 7'd14;
         5'd4: r = 7'd74;  5'd5: r = 7'd38;  5'd6: r = 7'd6;   5'd7: r = 7'd54;
         5'd8: r = 7'd18;  5'd9: r = 7'd70;  5'd10: r = 7'd34; 5'd11: r = 7'd10;
         5'd12: r = 7'd46; 5'd13: r = 7'd78; 5'd14: r = 7'd22; 5'd15: r = 7'd58;
         5'd16: r = 7'd30; 5'd17: r = 7'd66; 5'd18: r = 7'd42; 5'd19: r = 7'd50;
         default: r = {1'b0, idx[3:0] - 4'd3, 2'b00};
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/hlpa_front.sv
module hlpa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [7:0]            req_version,
   input  logic [7:0]            req_sender,
   input  logic [7:0]            req_receiver,
   input  logic [7:0]            req_message_type,
   input  logic [31:0]           req_sequence_req,
   input  logic [7:0]            req_left_duty,
   input  logic [7:0]            req_right_duty,
   input  logic [7:0]            req_button_bits,
   input  logic [7:0]            req_flag_bits,
   input  logic [15:0]           req_check_word,
   input  logic [31:0]           key_seed,
   input  logic [7:0]            hat_id,
   input  logic [7:0]            racer_id,
   output logic                  job_valid,
   input  logic                  job_ready,
   output hlpa_pkg::job_type     job
);
   import hlpa_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] hash_ff, hash_in;
   logic [95:0] bytes_ff, bytes_in;
   logic [15:0] chk_ff, chk_in;
   job_type     job_ff, job_in;
   logic [31:0] mixed;
   logic [31:0] folded;

   assign req_ready = !busy_ff && !done_ff;
   assign job_valid = done_ff;
   assign mixed = hash_ff ^ {24'd0, bytes_ff[7:0]};
   assign folded = hash_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in = cnt_ff;
      hash_in = hash_ff;
      bytes_in = bytes_ff;
      chk_in = chk_ff;
      job_in = job_ff;
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
         cnt_in = 4'd0;
         hash_in = key_seed;
         bytes_in = {req_flag_bits, req_button_bits, req_right_duty, req_left_duty,
                     req_sequence_req, req_message_type, req_receiver, req_sender,
                     req_version};
         chk_in = req_check_word;
         job_in.pkt = req_kind;
         job_in.hdr_ok = (req_version == LinkVersion) && (req_sender == hat_id)
                       && (req_receiver == racer_id) && (req_message_type == LinkMsgControl);
         job_in.seq = req_sequence_req;
         job_in.left = req_left_duty;
         job_in.right = req_right_duty;
         job_in.check_ok = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == 4'd12) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            job_in.check_ok = ((folded[15:0] ^ folded[31:16]) == chk_ff);
         end else begin
            hash_in = mixed * FnvPrime;
            bytes_in = {8'd0, bytes_ff[95:8]};
            cnt_in = cnt_ff + 4'd1;
         end
      end else if (done_ff && job_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      hash_ff <= hash_in;
      bytes_ff <= bytes_in;
      chk_ff <= chk_in;
      job_ff <= job_in;
   end

   assign job = job_ff;

endmodule

>>> hw/rtl/hlpa_queue.sv
module hlpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hlpa_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output hlpa_pkg::job_type out_job
);
   import hlpa_pkg::*;

   job_type    slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? !wp_ff : wp_ff;
      rp_in = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) slot_ff[wp_ff] <= in_job;
   end

endmodule

>>> hw/rtl/hlpa_back.sv
module hlpa_back #(
   parameter int HopCount = hlpa_pkg::HopCountDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  hlpa_pkg::job_type job,
   input  logic [15:0]       failsafe_ms,
   input  logic [15:0]       grace_ms,
   input  logic [7:0]        lookahead,
   input  logic [7:0]        tick_ms,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_listen_channel,
   output logic              rsp_accepted,
   output logic signed [7:0] rsp_left_drive,
   output logic signed [7:0] rsp_right_drive,
   output logic              rsp_motor_stop,
   output logic              rsp_in_sync
);
   import hlpa_pkg::*;

   // The hop index is (counter mod HopMod) / 10. The counter is folded by bytes
   // modulo HopMod, then reduced and divided by exact reciprocal multiplication.
   localparam int HopMod = HopCount * 10;
   localparam int ModB1 = 256 % HopMod;
   localparam int ModB2 = 65536 % HopMod;
   localparam int ModB3 = 16777216 % HopMod;
   localparam int RecipK = 27;
   localparam int RecipM = ((1 << RecipK) + HopMod - 1) / HopMod;
   localparam logic [17:0] TenthM = 18'd820;
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StHop = 2'd1;
   localparam logic [1:0] StOut = 2'd2;

   logic [1:0]  st_ff, st_in;
   logic [31:0] last_seq_ff, last_seq_in;
   logic        synced_ff, synced_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] good_ff, good_in;
   logic [4:0]  scan_ff, scan_in;
   logic [7:0]  step_ff, step_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [17:0] fold_ff, fold_in;
   logic [14:0] quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [1:0]  ph_ff, ph_in;
   logic        acc_ff, acc_in;
   logic        stop_ff, stop_in;
   logic [6:0]  chan_ff, chan_in;
   logic [7:0]  l_ff, l_in, r_ff, r_in;
   logic        fixed_ff, fixed_in;

   logic [31:0] el_new, age, dgap, since_fs;
   logic        valid, accept, scan, never;
   logic [31:0] cand;
   logic [4:0]  pos, pos_nxt;
   logic [8:0]  step_nxt;
   logic [17:0] fold_sum;
   logic [41:0] quo_prod;
   logic [23:0] quo_mul;
   logic [17:0] rem_wide;
   logic [17:0] tenth_prod;

   assign job_ready = st_ff == StIdle;
   assign rsp_valid = st_ff == StOut;
   assign rsp_listen_channel = chan_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_left_drive = l_ff;
   assign rsp_right_drive = r_ff;
   assign rsp_motor_stop = stop_ff;
   assign rsp_in_sync = synced_ff;

   always_comb begin
      el_new = elapsed_ff + {24'd0, tick_ms};
      age = job.seq - last_seq_ff;
      valid = job.pkt && job.hdr_ok && job.check_ok && age != 32'd0 && !age[31];
      never = last_seq_ff == SeqNever;
      dgap = el_new - good_ff;
      accept = 1'b0;
      scan = 1'b1;
      cand = last_seq_ff + 32'd1;
      pos = ({1'b0, scan_ff} < 6'(HopCount)) ? scan_ff : 5'd0;
      pos_nxt = ({1'b0, pos} + 6'd1 >= 6'(HopCount)) ? 5'd0 : pos + 5'd1;
      step_nxt = {1'b0, step_ff} + 9'd1;
      if (synced_ff) begin
         if (valid) begin
            accept = 1'b1;
            scan = 1'b0;
         end else if (dgap <= {16'd0, grace_ms}) begin
            scan = 1'b0;
         end
      end
      if (scan && !never) begin
         cand = last_seq_ff + {24'd0, step_ff};
         accept = valid && age <= {24'd0, lookahead};
      end else if (scan) begin
         accept = valid;
      end
      if (accept) cand = job.seq + 32'd1;
      since_fs = el_new - (accept ? el_new : good_ff);
      fold_sum = {10'd0, cnt_ff[7:0]} + {10'd0, cnt_ff[15:8]} * 18'(ModB1)
               + {10'd0, cnt_ff[23:16]} * 18'(ModB2) + {10'd0, cnt_ff[31:24]} * 18'(ModB3);
      quo_prod = {24'd0, fold_ff} * 42'(RecipM);
      quo_mul = {9'd0, quo_ff} * 24'(HopMod);
      rem_wide = fold_ff - quo_mul[17:0];
      tenth_prod = {9'd0, rem_ff} * TenthM;
   end

   always_comb begin
      st_in = st_ff;
      last_seq_in = last_seq_ff;
      synced_in = synced_ff;
      elapsed_in = elapsed_ff;
      good_in = good_ff;
      scan_in = scan_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      fold_in = fold_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      ph_in = ph_ff;
      acc_in = acc_ff;
      stop_in = stop_ff;
      chan_in = chan_ff;
      l_in = l_ff;
      r_in = r_ff;
      fixed_in = fixed_ff;
      unique case (st_ff)
         StIdle: begin
            if (job_valid) begin
               elapsed_in = el_new;
               acc_in = accept;
               l_in = accept ? job.left : 8'd0;
               r_in = accept ? job.right : 8'd0;
               fixed_in = 1'b0;
               if (scan && never && !accept) begin
                  chan_in = chan_lookup(pos);
                  scan_in = pos_nxt;
                  fixed_in = 1'b1;
               end else if (scan && !never && !accept) begin
                  step_in = (step_nxt > {1'b0, lookahead}) ? 8'd1 : step_nxt[7:0];
               end
               if (accept) begin
                  last_seq_in = job.seq;
                  good_in = el_new;
                  synced_in = 1'b1;
                  scan_in = 5'd0;
                  step_in = 8'd1;
               end
               stop_in = since_fs >= {16'd0, failsafe_ms};
               if (stop_in) synced_in = 1'b0;
               cnt_in = cand;
               ph_in = 2'd0;
               st_in = fixed_in ? StOut : StHop;
            end
         end
         StHop: begin
            ph_in = ph_ff + 2'd1;
            unique case (ph_ff)
               2'd0: fold_in = fold_sum;
               2'd1: quo_in = quo_prod[41:27];
               2'd2: rem_in = rem_wide[8:0];
               2'd3: begin
                  chan_in = chan_lookup(tenth_prod[17:13]);
                  st_in = StOut;
               end
            endcase
         end
         StOut: begin
            if (rsp_ready) st_in = StIdle;
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         last_seq_ff <= SeqNever;
         synced_ff <= 1'b0;
         elapsed_ff <= 32'd0;
         good_ff <= 32'd0;
         scan_ff <= 5'd0;
         step_ff <= 8'd1;
      end else begin
         st_ff <= st_in;
         last_seq_ff <= last_seq_in;
         synced_ff <= synced_in;
         elapsed_ff <= elapsed_in;
         good_ff <= good_in;
         scan_ff <= scan_in;
         step_ff <= step_in;
      end
      cnt_ff <= cnt_in;
      fold_ff <= fold_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      ph_ff <= ph_in;
      acc_ff <= acc_in;
      stop_ff <= stop_in;
      chan_ff <= chan_in;
      l_ff <= l_in;
      r_ff <= r_in;
      fixed_ff <= fixed_in;
   end

endmodule

>>> hw/rtl/hopping_link_packet_acceptor_top.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  one tick, optional packet
// rsp      out        rsp_valid/rsp_ready  channel, accept, drives, status
// csr      in         csr_write            register index and data
// The front end handles a tick in order: the transfer, twelve byte multiplies,
// the check compare and the hand-off into the queue.
// The back end maps a counter to a hop channel in four steps, but skips them
// while it walks the hop table; either way it can then stall on rsp.
// A two-entry queue lets the hash of the next tick run while a result stalls.
// Reset is synchronous and restores the CSRs, control state and link state.
module hopping_link_packet_acceptor_top #(
   parameter int HopCount = hlpa_pkg::HopCountDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [7:0]        req_version,
   input  logic [7:0]        req_sender,
   input  logic [7:0]        req_receiver,
   input  logic [7:0]        req_message_type,
   input  logic [31:0]       req_sequence_req,
   input  logic signed [7:0] req_left_duty,
   input  logic signed [7:0] req_right_duty,
   input  logic [7:0]        req_button_bits,
   input  logic [7:0]        req_flag_bits,
   input  logic [15:0]       req_check_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_listen_channel,
   output logic              rsp_accepted,
   output logic signed [7:0] rsp_left_drive,
   output logic signed [7:0] rsp_right_drive,
   output logic              rsp_motor_stop,
   output logic              rsp_in_sync,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import hlpa_pkg::*;

   logic [31:0] key_ff;
   logic [15:0] fs_ff, gr_ff;
   logic [7:0]  la_ff, tk_ff, hat_ff, racer_ff;
   logic        fj_valid, fj_ready, bj_valid, bj_ready;
   job_type     fj, bj;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= 32'h5A3C_9E27;
         fs_ff <= 16'd500;
         gr_ff <= 16'd120;
         la_ff <= 8'd60;
         tk_ff <= 8'd10;
         hat_ff <= 8'hA1;
         racer_ff <= 8'hB2;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrKeySeed: key_ff <= csr_data;
            CsrFailsafe: fs_ff <= csr_data[15:0];
            CsrGrace: gr_ff <= csr_data[15:0];
            CsrLookahead: la_ff <= csr_data[7:0];
            CsrTick: tk_ff <= csr_data[7:0];
            CsrHatId: hat_ff <= csr_data[7:0];
            CsrRacerId: racer_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   hlpa_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_version, .req_sender,
      .req_receiver, .req_message_type, .req_sequence_req,
      .req_left_duty(req_left_duty), .req_right_duty(req_right_duty),
      .req_button_bits, .req_flag_bits, .req_check_word,
      .key_seed(key_ff), .hat_id(hat_ff), .racer_id(racer_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   hlpa_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
   );

   hlpa_back #(.HopCount(HopCount)) u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .failsafe_ms(fs_ff), .grace_ms(gr_ff), .lookahead(la_ff), .tick_ms(tk_ff),
      .rsp_valid, .rsp_ready, .rsp_listen_channel, .rsp_accepted,
      .rsp_left_drive, .rsp_right_drive, .rsp_motor_stop, .rsp_in_sync
   );

   a_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_left_drive == 8'sd0 && rsp_right_drive == 8'sd0)
      else $error("drive without acceptance");
   a_stop_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_stop |-> !rsp_in_sync)
      else $error("sync kept after failsafe");
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      bj_valid && bj_ready |=> !rsp_accepted || !rsp_valid || $past(bj.pkt))
      else $error("acceptance without packet");

endmodule
